[hdl/ole_pkg.sv]
// Shared widths, codes and controller/datapath handshake types for the ordered list engine.
`default_nettype none

package ole_pkg;

   localparam int ACTION_W       = 4;
   localparam int VALUE_W        = 32;
   localparam int POSITION_W     = 7;
   localparam int STATUS_W       = 2;
   localparam int COUNT_W        = 7;
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_DATA_WIDTH = 32;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_ADD_HEAD  = 4'd0;
   localparam action_type ACT_ADD_TAIL  = 4'd1;
   localparam action_type ACT_INSERT_AT = 4'd2;
   localparam action_type ACT_REM_HEAD  = 4'd3;
   localparam action_type ACT_REM_TAIL  = 4'd4;
   localparam action_type ACT_REM_AT    = 4'd5;
   localparam action_type ACT_REM_VALUE = 4'd6;
   localparam action_type ACT_FIND      = 4'd7;
   localparam action_type ACT_CLEAR     = 4'd8;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_RANGE = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;
   localparam status_type STAT_FULL  = 2'd3;

   typedef logic [3:0] dp_op_type;

   localparam dp_op_type DP_NONE         = 4'd0;
   localparam dp_op_type DP_SET_RANGE    = 4'd1;
   localparam dp_op_type DP_SET_FULL     = 4'd2;
   localparam dp_op_type DP_SET_EMPTY    = 4'd3;
   localparam dp_op_type DP_CLEAR        = 4'd4;
   localparam dp_op_type DP_UP_SETUP     = 4'd5;
   localparam dp_op_type DP_SWEEP        = 4'd6;
   localparam dp_op_type DP_WRITE        = 4'd7;
   localparam dp_op_type DP_TAKE_RD      = 4'd8;
   localparam dp_op_type DP_TAKE_CAP     = 4'd9;
   localparam dp_op_type DP_SEARCH_SETUP = 4'd10;
   localparam dp_op_type DP_SEARCH       = 4'd11;
   localparam dp_op_type DP_RB_HEAD      = 4'd12;
   localparam dp_op_type DP_RB_TAIL      = 4'd13;
   localparam dp_op_type DP_RB_DONE      = 4'd14;
   localparam dp_op_type DP_LOAD         = 4'd15;

   typedef struct packed {
      logic      latch;
      dp_op_type op;
   } ole_cmd_type;

   typedef struct packed {
      logic is_add;
      logic is_rem_end;
      logic is_rem_at;
      logic is_search;
      logic is_rem_value;
      logic is_clear;
      logic ins_range;
      logic full;
      logic empty;
      logic rem_range;
      logic sweep_done;
      logic search_hit;
      logic out_free;
   } ole_sts_type;

endpackage

`default_nettype wire

[hdl/ole_if.sv]
// Request and response channel interfaces of the ordered list engine.
`default_nettype none

interface ole_req_if import ole_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [VALUE_W-1:0]    value;
   logic [POSITION_W-1:0] position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

interface ole_rsp_if import ole_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic [VALUE_W-1:0]         removed_value;
   logic                       found;
   logic signed [COUNT_W-1:0]  found_position;
   logic [COUNT_W-1:0]         count;
   logic [VALUE_W-1:0]         head_value;
   logic [VALUE_W-1:0]         tail_value;

   modport source (output valid, status, removed_value, found, found_position, count,
                   head_value, tail_value, input ready);
   modport sink   (input valid, status, removed_value, found, found_position, count,
                   head_value, tail_value, output ready);
endinterface

`default_nettype wire

[hdl/ordered_list_engine.sv]
// Top level of the ordered list engine: bounded ordered sequence with list operations.
//
// Usage: one request item on req_chan (action, value, position) gives exactly one
// response item on rsp_chan (status, removed value, search outcome, count, head and
// tail values after the request). Both channels use valid/ready; an item moves on a
// rising edge with both high.
// Requests are handled one at a time. A request is taken only while the engine is
// idle; the response is held in an output register, so the next request is taken
// while an earlier response still waits for rsp_chan.ready.
// Each request passes decode, then any memory sweep or search, then the head and tail
// read-back, before its response is loaded; sweeps and searches go one element at a
// time through the single read and single write port of the element memory.
// If the receiver stalls, the finished response waits in the engine until the
// output register is free.
// Reset (synchronous) empties the list and drops any pending response; the element
// memory is not cleared.
`default_nettype none

module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic clock,
   input  wire logic reset,
   ole_req_if.sink   req_chan,
   ole_rsp_if.source rsp_chan
);

   ole_cmd_type cmd;
   ole_sts_type sts;
   logic        ctrl_ready;

   assign req_chan.ready = ctrl_ready;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ole_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_chan.action),
      .req_value    (req_chan.value),
      .req_position (req_chan.position),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_chan     (rsp_chan)
   );

endmodule

`default_nettype wire

[hdl/ole_ctrl.sv]
// Sequencing state machine of the ordered list engine.
`default_nettype none

module ole_ctrl
   import ole_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire ole_sts_type sts,
   output      ole_cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SWEEP_UP = 4'd2;
   localparam logic [3:0] S_WRITE    = 4'd3;
   localparam logic [3:0] S_TAKE     = 4'd4;
   localparam logic [3:0] S_TAKE_CAP = 4'd5;
   localparam logic [3:0] S_SWEEP_DN = 4'd6;
   localparam logic [3:0] S_SEARCH   = 4'd7;
   localparam logic [3:0] S_RB_HEAD  = 4'd8;
   localparam logic [3:0] S_RB_TAIL  = 4'd9;
   localparam logic [3:0] S_RB_DONE  = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd.latch = 1'b0;
      cmd.op    = DP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (sts.is_add) begin
               priority if (sts.ins_range) begin
                  cmd.op   = DP_SET_RANGE;
                  state_in = S_RB_HEAD;
               end else if (sts.full) begin
                  cmd.op   = DP_SET_FULL;
                  state_in = S_RB_HEAD;
               end else begin
                  cmd.op   = DP_UP_SETUP;
                  state_in = S_SWEEP_UP;
               end
            end else if (sts.is_rem_end) begin
               if (sts.empty) begin
                  cmd.op   = DP_SET_EMPTY;
                  state_in = S_RB_HEAD;
               end else begin
                  state_in = S_TAKE;
               end
            end else if (sts.is_rem_at) begin
               if (sts.rem_range) begin
                  cmd.op   = DP_SET_RANGE;
                  state_in = S_RB_HEAD;
               end else begin
                  state_in = S_TAKE;
               end
            end else if (sts.is_search) begin
               cmd.op   = DP_SEARCH_SETUP;
               state_in = S_SEARCH;
            end else if (sts.is_clear) begin
               cmd.op   = DP_CLEAR;
               state_in = S_RB_HEAD;
            end else begin
               state_in = S_RB_HEAD;
            end
         end
         S_SWEEP_UP: begin
            cmd.op = DP_SWEEP;
            if (sts.sweep_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.op   = DP_WRITE;
            state_in = S_RB_HEAD;
         end
         S_TAKE: begin
            cmd.op   = DP_TAKE_RD;
            state_in = S_TAKE_CAP;
         end
         S_TAKE_CAP: begin
            cmd.op   = DP_TAKE_CAP;
            state_in = S_SWEEP_DN;
         end
         S_SWEEP_DN: begin
            cmd.op = DP_SWEEP;
            if (sts.sweep_done) begin
               state_in = S_RB_HEAD;
            end
         end
         S_SEARCH: begin
            cmd.op = DP_SEARCH;
            priority if (sts.search_hit) begin
               state_in = sts.is_rem_value ? S_TAKE : S_RB_HEAD;
            end else if (sts.sweep_done) begin
               state_in = S_RB_HEAD;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_RB_HEAD: begin
            cmd.op   = DP_RB_HEAD;
            state_in = S_RB_TAIL;
         end
         S_RB_TAIL: begin
            cmd.op   = DP_RB_TAIL;
            state_in = S_RB_DONE;
         end
         S_RB_DONE: begin
            cmd.op   = DP_RB_DONE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.op   = DP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ole_dp.sv]
// Datapath of the ordered list engine: element memory, count, sweep counters, result register.
`default_nettype none

module ole_dp
   import ole_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [VALUE_W-1:0]    req_value,
   input  wire logic [POSITION_W-1:0] req_position,
   input  wire ole_cmd_type           cmd,
   output      ole_sts_type           sts,
   ole_rsp_if.source                  rsp_chan
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] rdata_ff;

   action_type            act_ff, act_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [POSITION_W-1:0] pos_ff, pos_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         src_ff, src_in;
   logic [CW-1:0]         left_ff, left_in;
   logic [CW-1:0]         tgt_ff, tgt_in;
   logic                  up_ff, up_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] removed_ff, removed_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         hit_pos_ff, hit_pos_in;
   logic [DATA_WIDTH-1:0] head_ff, head_in;
   logic [DATA_WIDTH-1:0] tail_ff, tail_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]        rsp_removed_ff, rsp_removed_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]        rsp_fpos_ff, rsp_fpos_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]        rsp_head_ff, rsp_head_in;
   logic [VALUE_W-1:0]        rsp_tail_ff, rsp_tail_in;

   logic [63:0]     req_value_wide;
   logic [63:0]     removed_wide;
   logic [63:0]     head_wide;
   logic [63:0]     tail_wide;
   logic [63:0]     hit_pos_wide;
   logic [63:0]     cnt_wide;
   logic [CMPW-1:0] pos_x;
   logic [CMPW-1:0] cnt_x;
   logic [CW-1:0]   pos_cw;
   logic [CW-1:0]   cnt_m1;
   logic [CW-1:0]   ins_tgt;
   logic [CW-1:0]   rem_tgt;
   logic [CW-1:0]   src_p1;
   logic [CW-1:0]   src_m1;
   logic            cnt_zero;

   // value arrives 32 bits wide; keep its low DATA_WIDTH bits
   assign req_value_wide = {32'b0, req_value};
   assign removed_wide   = 64'(removed_ff);
   assign head_wide      = 64'(head_ff);
   assign tail_wide      = 64'(tail_ff);
   assign hit_pos_wide   = 64'(hit_pos_ff);
   assign cnt_wide       = 64'(cnt_ff);

   assign pos_x    = CMPW'(pos_ff);
   assign cnt_x    = CMPW'(cnt_ff);
   assign pos_cw   = pos_x[CW-1:0];
   assign cnt_m1   = cnt_ff - 1'b1;
   assign src_p1   = src_ff + 1'b1;
   assign src_m1   = src_ff - 1'b1;
   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      priority if (act_ff == ACT_ADD_HEAD) begin
         ins_tgt = '0;
      end else if (act_ff == ACT_ADD_TAIL) begin
         ins_tgt = cnt_ff;
      end else begin
         ins_tgt = pos_cw;
      end
   end

   always_comb begin
      priority if (act_ff == ACT_REM_HEAD) begin
         rem_tgt = '0;
      end else if (act_ff == ACT_REM_TAIL) begin
         rem_tgt = cnt_m1;
      end else if (act_ff == ACT_REM_AT) begin
         rem_tgt = pos_cw;
      end else begin
         rem_tgt = CW'(hit_pos_ff);
      end
   end

   assign sts.is_add       = (act_ff == ACT_ADD_HEAD) || (act_ff == ACT_ADD_TAIL) ||
                             (act_ff == ACT_INSERT_AT);
   assign sts.is_rem_end   = (act_ff == ACT_REM_HEAD) || (act_ff == ACT_REM_TAIL);
   assign sts.is_rem_at    = (act_ff == ACT_REM_AT);
   assign sts.is_search    = (act_ff == ACT_REM_VALUE) || (act_ff == ACT_FIND);
   assign sts.is_rem_value = (act_ff == ACT_REM_VALUE);
   assign sts.is_clear     = (act_ff == ACT_CLEAR);
   assign sts.ins_range    = (act_ff == ACT_INSERT_AT) && (pos_x > cnt_x);
   assign sts.full         = (cnt_ff == CW'(CAPACITY));
   assign sts.empty        = cnt_zero;
   assign sts.rem_range    = (pos_x >= cnt_x);
   assign sts.sweep_done   = (left_ff == '0) && !pend_ff;
   assign sts.search_hit   = pend_ff && (rdata_ff == val_ff);
   assign sts.out_free     = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      act_in         = act_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      src_in         = src_ff;
      left_in        = left_ff;
      tgt_in         = tgt_ff;
      up_in          = up_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      found_in       = found_ff;
      hit_pos_in     = hit_pos_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_fpos_in    = rsp_fpos_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_tail_in    = rsp_tail_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = rdata_ff;
      mem_raddr      = '0;

      if (cmd.latch) begin
         act_in     = req_action;
         val_in     = req_value_wide[DATA_WIDTH-1:0];
         pos_in     = req_position;
         status_in  = STAT_OK;
         removed_in = '0;
         found_in   = 1'b0;
      end

      unique case (cmd.op)
         DP_NONE: begin
         end
         DP_SET_RANGE: begin
            status_in = STAT_RANGE;
         end
         DP_SET_FULL: begin
            status_in = STAT_FULL;
         end
         DP_SET_EMPTY: begin
            status_in = STAT_EMPTY;
         end
         DP_CLEAR: begin
            cnt_in = '0;
         end
         DP_UP_SETUP: begin
            tgt_in  = ins_tgt;
            src_in  = cnt_m1;
            left_in = cnt_ff - ins_tgt;
            up_in   = 1'b1;
            pend_in = 1'b0;
         end
         DP_SWEEP: begin
            // read one slot, write it to its neighbour in the next cycle
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (left_ff != '0) begin
               mem_raddr    = src_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = up_ff ? src_p1[AW-1:0] : src_m1[AW-1:0];
               src_in       = up_ff ? src_m1 : src_p1;
               left_in      = left_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         DP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff[AW-1:0];
            mem_wdata = val_ff;
            cnt_in    = cnt_ff + 1'b1;
         end
         DP_TAKE_RD: begin
            tgt_in    = rem_tgt;
            mem_raddr = rem_tgt[AW-1:0];
         end
         DP_TAKE_CAP: begin
            removed_in = rdata_ff;
            src_in     = tgt_ff + 1'b1;
            left_in    = cnt_m1 - tgt_ff;
            up_in      = 1'b0;
            pend_in    = 1'b0;
            cnt_in     = cnt_m1;
         end
         DP_SEARCH_SETUP: begin
            src_in  = '0;
            left_in = cnt_ff;
            pend_in = 1'b0;
         end
         DP_SEARCH: begin
            priority if (sts.search_hit) begin
               found_in   = 1'b1;
               hit_pos_in = pend_addr_ff;
               pend_in    = 1'b0;
            end else if (left_ff != '0) begin
               mem_raddr    = src_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = src_ff[AW-1:0];
               src_in       = src_p1;
               left_in      = left_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         DP_RB_HEAD: begin
            mem_raddr = '0;
         end
         DP_RB_TAIL: begin
            head_in   = cnt_zero ? '0 : rdata_ff;
            mem_raddr = cnt_zero ? '0 : cnt_m1[AW-1:0];
         end
         DP_RB_DONE: begin
            tail_in = cnt_zero ? '0 : rdata_ff;
         end
         DP_LOAD: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = status_ff;
            rsp_removed_in = removed_wide[VALUE_W-1:0];
            rsp_found_in   = found_ff;
            rsp_fpos_in    = found_ff ? hit_pos_wide[COUNT_W-1:0] : '1;
            rsp_count_in   = cnt_wide[COUNT_W-1:0];
            rsp_head_in    = head_wide[VALUE_W-1:0];
            rsp_tail_in    = tail_wide[VALUE_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         left_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         left_ff      <= left_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      src_ff         <= src_in;
      tgt_ff         <= tgt_in;
      up_ff          <= up_in;
      pend_addr_ff   <= pend_addr_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      hit_pos_ff     <= hit_pos_in;
      head_ff        <= head_in;
      tail_ff        <= tail_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_fpos_ff    <= rsp_fpos_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_tail_ff    <= rsp_tail_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.removed_value  = rsp_removed_ff;
   assign rsp_chan.found          = rsp_found_ff;
   assign rsp_chan.found_position = rsp_fpos_ff;
   assign rsp_chan.count          = rsp_count_ff;
   assign rsp_chan.head_value     = rsp_head_ff;
   assign rsp_chan.tail_value     = rsp_tail_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_sweep_no_alias: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_SWEEP && mem_we && left_ff != '0) |-> mem_waddr != mem_raddr)
      else $error("sweep writes the slot it reads");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_LOAD) |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result item overwritten before it was taken");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_LOAD) |=> rsp_valid_ff)
      else $error("loaded result item not presented");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_WRITE) |-> (cnt_ff != CW'(CAPACITY)))
      else $error("element added to a full list");
`endif

endmodule

`default_nettype wire
